FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/lsr_pkg.sv
`timescale 1ns / 1ps

package lsr_pkg;

   // minor axis step per span
   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_UP   = 2'b01;
   localparam logic [1:0] DIR_DOWN = 2'b11;

   typedef struct packed {
      logic              busy;
      logic              steep;
      logic signed [12:0] major_pos;
      logic signed [12:0] major_end;
      logic signed [11:0] minor_pos;
      logic [1:0]        minor_dir;
      logic [11:0]       minor_delta;
      logic [11:0]       err_inc;     // major_delta - minor_delta
      logic [12:0]       err_acc;
   } line_type;

endpackage

FILE: rtl/core/line_span_rasterizer.sv
`timescale 1ns / 1ps
// Line span rasterizer, Bresenham run slicing.
// req_ channel: action 0 loads two endpoints (no result), action 1 asks for
// the next span of the loaded line (exactly one result on rsp_).
// A load writes the line register. A step walks the error accumulator one
// major position per cycle through a single shared subtract/compare unit
// and then writes its span to the output register; an axis-aligned line
// jumps straight to its run end, and a step with no line loaded skips the walk.
// req_stall is high from a step's acceptance until its result is written.
// The result sits in an output register; the next item is accepted while it
// waits. If rsp_stall holds that register full, the following step finishes
// its run and then waits until the register frees up.
// Steps after the last span return span_valid 0 with line_done 1.
// Synchronous reset clears the loaded line and empties the output register.
`include "assert_macros.svh"

module line_span_rasterizer #(
   parameter int SCREEN_COLS = 720,
   parameter int SCREEN_ROWS = 348
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic signed [11:0] req_x_a,
   input  logic signed [11:0] req_y_a,
   input  logic signed [11:0] req_x_b,
   input  logic signed [11:0] req_y_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_span_valid,
   output logic               rsp_span_vertical,
   output logic signed [11:0] rsp_span_fixed,
   output logic signed [11:0] rsp_span_start,
   output logic signed [11:0] rsp_span_end,
   output logic               rsp_line_done
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]         state_ff, state_in;
   lsr_pkg::line_type  line_ff, line_in, line_load;
   logic signed [11:0] start_ff, start_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               span_valid_ff, span_valid_in;
   logic               span_vert_ff, span_vert_in;
   logic signed [11:0] span_fixed_ff, span_fixed_in;
   logic signed [11:0] span_start_ff, span_start_in;
   logic signed [11:0] span_end_ff, span_end_in;
   logic               line_done_ff, line_done_in;

   logic               req_take, out_free, can_step, more;
   logic [13:0]        err_diff;
   logic signed [11:0] minor_next;

   lsr_setup #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_setup (
      .x_a      (req_x_a),
      .y_a      (req_y_a),
      .x_b      (req_x_b),
      .y_b      (req_y_b),
      .line_out (line_load)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // shared unit: err_acc - minor_delta, borrow doubles as the compare
   assign err_diff = {1'b0, line_ff.err_acc} - {2'b00, line_ff.minor_delta};
   assign can_step = (line_ff.major_pos < line_ff.major_end) && !err_diff[13];
   assign more     = (line_ff.major_pos < line_ff.major_end);

   always_comb begin
      unique case (line_ff.minor_dir)
         lsr_pkg::DIR_UP:   minor_next = line_ff.minor_pos + 12'sd1;
         lsr_pkg::DIR_DOWN: minor_next = line_ff.minor_pos - 12'sd1;
         default:           minor_next = line_ff.minor_pos;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      line_in       = line_ff;
      start_in      = start_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      span_valid_in = span_valid_ff;
      span_vert_in  = span_vert_ff;
      span_fixed_in = span_fixed_ff;
      span_start_in = span_start_ff;
      span_end_in   = span_end_ff;
      line_done_in  = line_done_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (!req_action) begin
                  line_in = line_load;
               end else begin
                  start_in = line_ff.major_pos[11:0];
                  state_in = line_ff.busy ? S_RUN : S_EMIT;
               end
            end
         end
         S_RUN: begin
            priority if (line_ff.minor_delta == '0) begin
               // axis line: the whole remainder is one span
               line_in.major_pos = line_ff.major_end;
               state_in          = S_EMIT;
            end else if (can_step) begin
               line_in.err_acc   = err_diff[12:0];
               line_in.major_pos = line_ff.major_pos + 13'sd1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (line_ff.busy) begin
                  span_valid_in     = 1'b1;
                  span_vert_in      = line_ff.steep;
                  span_fixed_in     = line_ff.minor_pos;
                  span_start_in     = start_ff;
                  span_end_in       = line_ff.major_pos[11:0];
                  line_done_in      = !more;
                  line_in.busy      = more;
                  line_in.major_pos = line_ff.major_pos + 13'sd1;
                  line_in.err_acc   = line_ff.err_acc + {1'b0, line_ff.err_inc};
                  line_in.minor_pos = minor_next;
               end else begin
                  span_valid_in = 1'b0;
                  span_vert_in  = 1'b0;
                  span_fixed_in = '0;
                  span_start_in = '0;
                  span_end_in   = '0;
                  line_done_in  = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      span_valid_ff <= span_valid_in;
      span_vert_ff  <= span_vert_in;
      span_fixed_ff <= span_fixed_in;
      span_start_ff <= span_start_in;
      span_end_ff   <= span_end_in;
      line_done_ff  <= line_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_span_valid    = span_valid_ff;
   assign rsp_span_vertical = span_vert_ff;
   assign rsp_span_fixed    = span_fixed_ff;
   assign rsp_span_start    = span_start_ff;
   assign rsp_span_end      = span_end_ff;
   assign rsp_line_done     = line_done_ff;

   `ASSERT_ALWAYS(a_run_busy, clock, reset, (state_ff != S_RUN) || line_ff.busy)
   `ASSERT_ALWAYS(a_run_in_range, clock, reset,
      (state_ff != S_RUN) || (line_ff.major_pos <= line_ff.major_end))
   `ASSERT_NEXT(a_emit_writes, clock, reset, (state_ff == S_EMIT) && out_free,
      rsp_valid_ff && (state_ff == S_IDLE))
   `ASSERT_ALWAYS(a_axis_no_delta, clock, reset,
      !line_ff.busy || (line_ff.minor_dir != lsr_pkg::DIR_NONE) ||
      (line_ff.minor_delta == '0))

endmodule

FILE: rtl/core/lsr_setup.sv
`timescale 1ns / 1ps

module lsr_setup #(
   parameter int SCREEN_COLS = 720,
   parameter int SCREEN_ROWS = 348
) (
   input  logic signed [11:0] x_a,
   input  logic signed [11:0] y_a,
   input  logic signed [11:0] x_b,
   input  logic signed [11:0] y_b,
   output lsr_pkg::line_type  line_out
);

   localparam logic signed [12:0] COL_LIM = 13'(SCREEN_COLS);
   localparam logic signed [12:0] ROW_LIM = 13'(SCREEN_ROWS);

   logic signed [12:0] dx, dy;
   logic [11:0]        adx, ady;
   logic               steep;
   logic signed [11:0] ma, mb, na, nb;
   logic signed [11:0] ma_s, mb_s, na_s, nb_s;
   logic [11:0]        dmaj, dmin;

   logic               axis_vert, axis_horz;
   logic signed [12:0] ax_fixed, ax_a, ax_b, ax_lo, ax_hi;
   logic signed [12:0] fixed_lim, run_lim, lo_c, hi_c;
   logic               ax_keep;

   // diagonal line: order along the major axis
   assign dx    = {x_b[11], x_b} - {x_a[11], x_a};
   assign dy    = {y_b[11], y_b} - {y_a[11], y_a};
   assign adx   = dx[12] ? 12'(-dx) : dx[11:0];
   assign ady   = dy[12] ? 12'(-dy) : dy[11:0];
   assign steep = (ady >= adx);
   assign dmaj  = steep ? ady : adx;
   assign dmin  = steep ? adx : ady;
   assign ma    = steep ? y_a : x_a;
   assign mb    = steep ? y_b : x_b;
   assign na    = steep ? x_a : y_a;
   assign nb    = steep ? x_b : y_b;
   assign ma_s  = (ma > mb) ? mb : ma;
   assign mb_s  = (ma > mb) ? ma : mb;
   assign na_s  = (ma > mb) ? nb : na;
   assign nb_s  = (ma > mb) ? na : nb;

   // axis-aligned line: clip to the screen
   assign axis_vert = (x_a == x_b);
   assign axis_horz = (y_a == y_b);
   assign ax_fixed  = axis_vert ? {x_a[11], x_a} : {y_a[11], y_a};
   assign ax_a      = axis_vert ? {y_a[11], y_a} : {x_a[11], x_a};
   assign ax_b      = axis_vert ? {y_b[11], y_b} : {x_b[11], x_b};
   assign fixed_lim = axis_vert ? COL_LIM : ROW_LIM;
   assign run_lim   = axis_vert ? ROW_LIM : COL_LIM;
   assign ax_lo     = (ax_a < ax_b) ? ax_a : ax_b;
   assign ax_hi     = (ax_a < ax_b) ? ax_b : ax_a;
   assign lo_c      = (ax_lo < 13'sd0) ? 13'sd0 : ((ax_lo > run_lim) ? run_lim : ax_lo);
   assign hi_c      = (ax_hi < -13'sd1) ? -13'sd1 :
                      ((ax_hi > run_lim - 13'sd1) ? run_lim - 13'sd1 : ax_hi);
   assign ax_keep   = (ax_fixed >= 13'sd0) && (ax_fixed < fixed_lim) && (lo_c <= hi_c);

   always_comb begin
      if (axis_vert || axis_horz) begin
         line_out.busy        = ax_keep;
         line_out.steep       = axis_vert;
         line_out.major_pos   = lo_c;
         line_out.major_end   = hi_c;
         line_out.minor_pos   = ax_fixed[11:0];
         line_out.minor_dir   = lsr_pkg::DIR_NONE;
         line_out.minor_delta = '0;
         line_out.err_inc     = '0;
         line_out.err_acc     = '0;
      end else begin
         line_out.busy        = 1'b1;
         line_out.steep       = steep;
         line_out.major_pos   = {ma_s[11], ma_s};
         line_out.major_end   = {mb_s[11], mb_s};
         line_out.minor_pos   = na_s;
         line_out.minor_dir   = (nb_s > na_s) ? lsr_pkg::DIR_UP : lsr_pkg::DIR_DOWN;
         line_out.minor_delta = dmin;
         line_out.err_inc     = dmaj - dmin;
         line_out.err_acc     = {2'b00, dmaj[11:1]};
      end
   end

endmodule
